### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// S-box, round constants and the byte-level round functions used by the
// round stage and the key schedule.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NumRounds = 10;

    typedef logic [127:0] t_block;
    typedef logic [31:0]  t_word;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] y;
        case (x)
            8'h00: y=8'h63; 8'h01: y=8'h7c; 8'h02: y=8'h77; 8'h03: y=8'h7b;
            8'h04: y=8'hf2; 8'h05: y=8'h6b; 8'h06: y=8'h6f; 8'h07: y=8'hc5;
            8'h08: y=8'h30; 8'h09: y=8'h01; 8'h0a: y=8'h67; 8'h0b: y=8'h2b;
            8'h0c: y=8'hfe; 8'h0d: y=8'hd7; 8'h0e: y=8'hab; 8'h0f: y=8'h76;
            8'h10: y=8'hca; 8'h11: y=8'h82; 8'h12: y=8'hc9; 8'h13: y=8'h7d;
            8'h14: y=8'hfa; 8'h15: y=8'h59; 8'h16: y=8'h47; 8'h17: y=8'hf0;
            8'h18: y=8'had; 8'h19: y=8'hd4; 8'h1a: y=8'ha2; 8'h1b: y=8'haf;
            8'h1c: y=8'h9c; 8'h1d: y=8'ha4; 8'h1e: y=8'h72; 8'h1f: y=8'hc0;
            8'h20: y=8'hb7; 8'h21: y=8'hfd; 8'h22: y=8'h93; 8'h23: y=8'h26;
            8'h24: y=8'h36; 8'h25: y=8'h3f; 8'h26: y=8'hf7; 8'h27: y=8'hcc;
            8'h28: y=8'h34; 8'h29: y=8'ha5; 8'h2a: y=8'he5; 8'h2b: y=8'hf1;
            8'h2c: y=8'h71; 8'h2d: y=8'hd8; 8'h2e: y=8'h31; 8'h2f: y=8'h15;
            8'h30: y=8'h04; 8'h31: y=8'hc7; 8'h32: y=8'h23; 8'h33: y=8'hc3;
            8'h34: y=8'h18; 8'h35: y=8'h96; 8'h36: y=8'h05; 8'h37: y=8'h9a;
            8'h38: y=8'h07; 8'h39: y=8'h12; 8'h3a: y=8'h80; 8'h3b: y=8'he2;
            8'h3c: y=8'heb; 8'h3d: y=8'h27; 8'h3e: y=8'hb2; 8'h3f: y=8'h75;
            8'h40: y=8'h09; 8'h41: y=8'h83; 8'h42: y=8'h2c; 8'h43: y=8'h1a;
            8'h44: y=8'h1b; 8'h45: y=8'h6e; 8'h46: y=8'h5a; 8'h47: y=8'ha0;
            8'h48: y=8'h52; 8'h49: y=8'h3b; 8'h4a: y=8'hd6; 8'h4b: y=8'hb3;
            8'h4c: y=8'h29; 8'h4d: y=8'he3; 8'h4e: y=8'h2f; 8'h4f: y=8'h84;
            8'h50: y=8'h53; 8'h51: y=8'hd1; 8'h52: y=8'h00; 8'h53: y=8'hed;
            8'h54: y=8'h20; 8'h55: y=8'hfc; 8'h56: y=8'hb1; 8'h57: y=8'h5b;
            8'h58: y=8'h6a; 8'h59: y=8'hcb; 8'h5a: y=8'hbe; 8'h5b: y=8'h39;
            8'h5c: y=8'h4a; 8'h5d: y=8'h4c; 8'h5e: y=8'h58; 8'h5f: y=8'hcf;
            8'h60: y=8'hd0; 8'h61: y=8'hef; 8'h62: y=8'haa; 8'h63: y=8'hfb;
            8'h64: y=8'h43; 8'h65: y=8'h4d; 8'h66: y=8'h33; 8'h67: y=8'h85;
            8'h68: y=8'h45; 8'h69: y=8'hf9; 8'h6a: y=8'h02; 8'h6b: y=8'h7f;
            8'h6c: y=8'h50; 8'h6d: y=8'h3c; 8'h6e: y=8'h9f; 8'h6f: y=8'ha8;
            8'h70: y=8'h51; 8'h71: y=8'ha3; 8'h72: y=8'h40; 8'h73: y=8'h8f;
            8'h74: y=8'h92; 8'h75: y=8'h9d; 8'h76: y=8'h38; 8'h77: y=8'hf5;
            8'h78: y=8'hbc; 8'h79: y=8'hb6; 8'h7a: y=8'hda; 8'h7b: y=8'h21;
            8'h7c: y=8'h10; 8'h7d: y=8'hff; 8'h7e: y=8'hf3; 8'h7f: y=8'hd2;
            8'h80: y=8'hcd; 8'h81: y=8'h0c; 8'h82: y=8'h13; 8'h83: y=8'hec;
            8'h84: y=8'h5f; 8'h85: y=8'h97; 8'h86: y=8'h44; 8'h87: y=8'h17;
            8'h88: y=8'hc4; 8'h89: y=8'ha7; 8'h8a: y=8'h7e; 8'h8b: y=8'h3d;
            8'h8c: y=8'h64; 8'h8d: y=8'h5d; 8'h8e: y=8'h19; 8'h8f: y=8'h73;
            8'h90: y=8'h60; 8'h91: y=8'h81; 8'h92: y=8'h4f; 8'h93: y=8'hdc;
            8'h94: y=8'h22; 8'h95: y=8'h2a; 8'h96: y=8'h90; 8'h97: y=8'h88;
            8'h98: y=8'h46; 8'h99: y=8'hee; 8'h9a: y=8'hb8; 8'h9b: y=8'h14;
            8'h9c: y=8'hde; 8'h9d: y=8'h5e; 8'h9e: y=8'h0b; 8'h9f: y=8'hdb;
            8'ha0: y=8'he0; 8'ha1: y=8'h32; 8'ha2: y=8'h3a; 8'ha3: y=8'h0a;
            8'ha4: y=8'h49; 8'ha5: y=8'h06; 8'ha6: y=8'h24; 8'ha7: y=8'h5c;
            8'ha8: y=8'hc2; 8'ha9: y=8'hd3; 8'haa: y=8'hac; 8'hab: y=8'h62;
            8'hac: y=8'h91; 8'had: y=8'h95; 8'hae: y=8'he4; 8'haf: y=8'h79;
            8'hb0: y=8'he7; 8'hb1: y=8'hc8; 8'hb2: y=8'h37; 8'hb3: y=8'h6d;
            8'hb4: y=8'h8d; 8'hb5: y=8'hd5; 8'hb6: y=8'h4e; 8'hb7: y=8'ha9;
            8'hb8: y=8'h6c; 8'hb9: y=8'h56; 8'hba: y=8'hf4; 8'hbb: y=8'hea;
            8'hbc: y=8'h65; 8'hbd: y=8'h7a; 8'hbe: y=8'hae; 8'hbf: y=8'h08;
            8'hc0: y=8'hba; 8'hc1: y=8'h78; 8'hc2: y=8'h25; 8'hc3: y=8'h2e;
            8'hc4: y=8'h1c; 8'hc5: y=8'ha6; 8'hc6: y=8'hb4; 8'hc7: y=8'hc6;
            8'hc8: y=8'he8; 8'hc9: y=8'hdd; 8'hca: y=8'h74; 8'hcb: y=8'h1f;
            8'hcc: y=8'h4b; 8'hcd: y=8'hbd; 8'hce: y=8'h8b; 8'hcf: y=8'h8a;
            8'hd0: y=8'h70; 8'hd1: y=8'h3e; 8'hd2: y=8'hb5; 8'hd3: y=8'h66;
            8'hd4: y=8'h48; 8'hd5: y=8'h03; 8'hd6: y=8'hf6; 8'hd7: y=8'h0e;
            8'hd8: y=8'h61; 8'hd9: y=8'h35; 8'hda: y=8'h57; 8'hdb: y=8'hb9;
            8'hdc: y=8'h86; 8'hdd: y=8'hc1; 8'hde: y=8'h1d; 8'hdf: y=8'h9e;
            8'he0: y=8'he1; 8'he1: y=8'hf8; 8'he2: y=8'h98; 8'he3: y=8'h11;
            8'he4: y=8'h69; 8'he5: y=8'hd9; 8'he6: y=8'h8e; 8'he7: y=8'h94;
            8'he8: y=8'h9b; 8'he9: y=8'h1e; 8'hea: y=8'h87; 8'heb: y=8'he9;
            8'hec: y=8'hce; 8'hed: y=8'h55; 8'hee: y=8'h28; 8'hef: y=8'hdf;
            8'hf0: y=8'h8c; 8'hf1: y=8'ha1; 8'hf2: y=8'h89; 8'hf3: y=8'h0d;
            8'hf4: y=8'hbf; 8'hf5: y=8'he6; 8'hf6: y=8'h42; 8'hf7: y=8'h68;
            8'hf8: y=8'h41; 8'hf9: y=8'h99; 8'hfa: y=8'h2d; 8'hfb: y=8'h0f;
            8'hfc: y=8'hb0; 8'hfd: y=8'h54; 8'hfe: y=8'hbb; 8'hff: y=8'h16;
            default: y = 8'h00;
        endcase
        return y;
    endfunction

    // Round constant for key-schedule step r (1..10).
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] y;
        case (r)
            4'd1:  y = 8'h01;
            4'd2:  y = 8'h02;
            4'd3:  y = 8'h04;
            4'd4:  y = 8'h08;
            4'd5:  y = 8'h10;
            4'd6:  y = 8'h20;
            4'd7:  y = 8'h40;
            4'd8:  y = 8'h80;
            4'd9:  y = 8'h1b;
            4'd10: y = 8'h36;
            default: y = 8'h00;
        endcase
        return y;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block, byte 0 in the top bits.
    function automatic logic [7:0] blk_byte(input t_block b, input int unsigned i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = sbox(blk_byte(s, r + 4*((c + r) % 4)));
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = blk_byte(s, 4*c);
            a1 = blk_byte(s, 4*c + 1);
            a2 = blk_byte(s, 4*c + 2);
            a3 = blk_byte(s, 4*c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 8*(4*c)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // One key-schedule step: round key r-1 to round key r.
    function automatic t_block next_key(input t_block k, input logic [3:0] r);
        t_word w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

### rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES-128 round stage
// One pipeline stage: a cipher round on the state and the matching key
// schedule step, both registered. The last round skips MixColumns.
// ----------------------------------------------------------------------------
module aes_round #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_key,
    output logic            o_valid,
    output aes_pkg::t_block o_state,
    output aes_pkg::t_block o_key
);

    aes_pkg::t_block r_state, r_key, n_state, n_key, w_sub;
    logic            r_valid;

    always_comb begin
        n_key = aes_pkg::next_key(i_key, ROUND);
        w_sub = aes_pkg::sub_shift(i_state);
        if (ROUND == 4'(aes_pkg::NumRounds)) begin
            n_state = w_sub ^ n_key;
        end else begin
            n_state = aes_pkg::mix_columns(w_sub) ^ n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

### rtl/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Fully pipelined AES-128 encryptor, one round per stage, key expanded
// alongside the data.
//
//   channel | direction | handshake          | payload
//   in      | input     | i_valid / o_stall  | i_plaintext_high/low
//   out     | output    | o_valid / i_stall  | o_ciphertext_high/low
//   cfg     | input     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; an initial AddRoundKey
// register is followed by ten round stages. The whole pipeline holds while
// the output is stalled with a valid result, so nothing is lost or repeated.
// Reset clears the valid bits and sets both key halves to 0x0101010101010101.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_plaintext_high,
    input  logic [63:0] i_plaintext_low,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_ciphertext_high,
    output logic [63:0] o_ciphertext_low
);

    localparam logic KeyHighIdx = 1'b0;
    localparam logic KeyLowIdx  = 1'b1;

    logic [63:0]     r_key_high, r_key_low;
    logic            w_adv;
    logic            r_valid0;
    aes_pkg::t_block r_state0, r_key0;

    logic            w_valid [0:aes_pkg::NumRounds];
    aes_pkg::t_block w_state [0:aes_pkg::NumRounds];
    aes_pkg::t_block w_key   [0:aes_pkg::NumRounds];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= 64'h0101010101010101;
            r_key_low  <= 64'h0101010101010101;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                KeyHighIdx: r_key_high <= i_cfg_data;
                KeyLowIdx:  r_key_low  <= i_cfg_data;
                default:    r_key_high <= r_key_high;
            endcase
        end
    end

    // The pipeline moves unless a finished result is held at the output.
    assign w_adv   = !(w_valid[aes_pkg::NumRounds] && i_stall);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (w_adv) begin
            r_valid0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_state0 <= {i_plaintext_high, i_plaintext_low} ^ {r_key_high, r_key_low};
            r_key0   <= {r_key_high, r_key_low};
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_state[0] = r_state0;
    assign w_key[0]   = r_key0;

    for (genvar g = 1; g <= aes_pkg::NumRounds; g++) begin : g_round
        aes_round #(
            .ROUND(4'(g))
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g-1]),
            .i_state (w_state[g-1]),
            .i_key   (w_key[g-1]),
            .o_valid (w_valid[g]),
            .o_state (w_state[g]),
            .o_key   (w_key[g])
        );
    end

    assign o_valid           = w_valid[aes_pkg::NumRounds];
    assign o_ciphertext_high = w_state[aes_pkg::NumRounds][127:64];
    assign o_ciphertext_low  = w_state[aes_pkg::NumRounds][63:0];

endmodule
